>>> sv/nsc_pkg.sv
`timescale 1ns / 1ps

package nsc_pkg;

  // field and bus widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned TagW   = 24;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned IndexW = 2;

  // special bytes
  localparam logic [CharW-1:0] STAR_CHAR    = 8'h2A;
  localparam logic [CharW-1:0] NEWLINE_CHAR = 8'h0A;

  // register indexes
  localparam logic [IndexW-1:0] REG_TAG_FIRST  = 2'd0;
  localparam logic [IndexW-1:0] REG_TAG_SECOND = 2'd1;
  localparam logic [IndexW-1:0] REG_TAG_THIRD  = 2'd2;

  // tag reset values: GGA, RMC, ZDA
  localparam logic [TagW-1:0] TAG_FIRST_RST  = 24'h474741;
  localparam logic [TagW-1:0] TAG_SECOND_RST = 24'h524D43;
  localparam logic [TagW-1:0] TAG_THIRD_RST  = 24'h5A4441;

  // verdict codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_STAR  = 2'd1;
  localparam logic [1:0] STATUS_BAD_TEXT = 2'd2;
  localparam logic [1:0] STATUS_MISMATCH = 2'd3;

  // sentence kinds
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_FIRST   = 2'd1;
  localparam logic [1:0] KIND_SECOND  = 2'd2;
  localparam logic [1:0] KIND_THIRD   = 2'd3;

  // checksum tail phases
  localparam logic [1:0] TAIL_DIGITS  = 2'd0;
  localparam logic [1:0] TAIL_NEWLINE = 2'd1;
  localparam logic [1:0] TAIL_BAD     = 2'd2;

  // tag registers as seen by the core
  typedef struct packed {
    logic [TagW-1:0] tag_first;
    logic [TagW-1:0] tag_second;
    logic [TagW-1:0] tag_third;
  } nsc_tags_t;

endpackage

>>> sv/nsc_in_if.sv
`timescale 1ns / 1ps

// byte channel into the checker
interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_sentence;

  modport source (output valid, output char_in, output end_of_sentence, input ready);
  modport sink   (input valid, input char_in, input end_of_sentence, output ready);
endinterface

>>> sv/nsc_out_if.sv
`timescale 1ns / 1ps

// verdict channel out of the checker
interface nsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] sentence_kind;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;

  modport source (output valid, output status, output sentence_kind,
                  output computed_sum, output received_sum, input ready);
  modport sink   (input valid, input status, input sentence_kind,
                  input computed_sum, input received_sum, output ready);
endinterface

>>> sv/nsc_apb_regs.sv
`timescale 1ns / 1ps

module nsc_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nsc_pkg::AddrW-1:0]      paddr,
  input  logic [nsc_pkg::DataW-1:0]      pwdata,
  output logic [nsc_pkg::DataW-1:0]      prdata,
  output logic                           pready,
  output nsc_pkg::nsc_tags_t             tags_o
);

  logic [nsc_pkg::TagW-1:0]   tag_first_q, tag_second_q, tag_third_q;
  logic [nsc_pkg::IndexW-1:0] index_s;
  logic                       wr_s;
  logic [nsc_pkg::TagW-1:0]   rd_tag_s;
  logic                       rd_hit_s;

  assign pready  = 1'b1;
  assign index_s = paddr[nsc_pkg::AddrW-1:2];
  assign wr_s    = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_first_q  <= nsc_pkg::TAG_FIRST_RST;
      tag_second_q <= nsc_pkg::TAG_SECOND_RST;
      tag_third_q  <= nsc_pkg::TAG_THIRD_RST;
    end else if (wr_s) begin
      unique case (index_s)
        nsc_pkg::REG_TAG_FIRST:  tag_first_q  <= pwdata[nsc_pkg::TagW-1:0];
        nsc_pkg::REG_TAG_SECOND: tag_second_q <= pwdata[nsc_pkg::TagW-1:0];
        nsc_pkg::REG_TAG_THIRD:  tag_third_q  <= pwdata[nsc_pkg::TagW-1:0];
        default: ;
      endcase
    end
  end

  // read mux, unmapped addresses read as zero
  always_comb begin
    rd_tag_s = '0;
    rd_hit_s = 1'b1;
    unique case (index_s)
      nsc_pkg::REG_TAG_FIRST:  rd_tag_s = tag_first_q;
      nsc_pkg::REG_TAG_SECOND: rd_tag_s = tag_second_q;
      nsc_pkg::REG_TAG_THIRD:  rd_tag_s = tag_third_q;
      default:                 rd_hit_s = 1'b0;
    endcase
  end

  assign prdata = rd_hit_s ? {{(nsc_pkg::DataW-nsc_pkg::TagW){1'b0}}, rd_tag_s} : '0;

  assign tags_o.tag_first  = tag_first_q;
  assign tags_o.tag_second = tag_second_q;
  assign tags_o.tag_third  = tag_third_q;

endmodule

>>> sv/nsc_core.sv
`timescale 1ns / 1ps

module nsc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nsc_pkg::nsc_tags_t tags_i,
  nsc_in_if.sink             in_i,
  nsc_out_if.source          out_o
);

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_eos_q;

  // sentence state
  logic [7:0]  xor_q, xor_d;
  logic        first_q, first_d;
  logic        star_q, star_d;
  logic [7:0]  hex_q, hex_d;
  logic        ovf_q, ovf_d;
  logic [1:0]  tail_q, tail_d;
  logic [15:0] recent_q, recent_d;
  logic [2:0]  hits_q, hits_d;
  logic [1:0]  fill_q, fill_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] csum_q, csum_d;
  logic [7:0] rsum_q, rsum_d;

  logic        advance_s;
  logic [23:0] win_s;
  logic [4:0]  dig_s;

  assign advance_s = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~in_valid_q | advance_s;
  assign win_s = {recent_q, in_char_q};
  assign dig_s = hex_digit(in_char_q);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q <= in_i.char_in;
      in_eos_q  <= in_i.end_of_sentence;
    end
  end

  // per-byte update and verdict
  always_comb begin
    xor_d       = xor_q;
    first_d     = first_q;
    star_d      = star_q;
    hex_d       = hex_q;
    ovf_d       = ovf_q;
    tail_d      = tail_q;
    recent_d    = recent_q;
    hits_d      = hits_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    status_d    = nsc_pkg::STATUS_OK;
    kind_d      = nsc_pkg::KIND_UNKNOWN;
    csum_d      = '0;
    rsum_d      = '0;
    if (advance_s) begin
      // tag window over the last three bytes
      if (fill_q == 2'd2) begin
        if (win_s == tags_i.tag_first)  hits_d[0] = 1'b1;
        if (win_s == tags_i.tag_second) hits_d[1] = 1'b1;
        if (win_s == tags_i.tag_third)  hits_d[2] = 1'b1;
      end
      recent_d = win_s[15:0];
      if (fill_q != 2'd2) fill_d = fill_q + 2'd1;

      // checksum body and tail
      if (star_q) begin
        if (tail_q == nsc_pkg::TAIL_DIGITS) begin
          if (dig_s[4]) begin
            if (ovf_q || hex_q[7:4] != 4'd0) begin
              ovf_d = 1'b1;
              hex_d = 8'hFF;
            end else begin
              hex_d = {hex_q[3:0], dig_s[3:0]};
            end
          end else if (in_char_q == nsc_pkg::NEWLINE_CHAR) begin
            tail_d = nsc_pkg::TAIL_NEWLINE;
          end else begin
            tail_d = nsc_pkg::TAIL_BAD;
          end
        end
      end else if (in_char_q == nsc_pkg::STAR_CHAR) begin
        star_d = 1'b1;
      end else if (!first_q) begin
        xor_d = xor_q ^ in_char_q;
      end
      first_d = 1'b0;

      // verdict on the final byte
      if (in_eos_q) begin
        if (hits_d[0])      kind_d = nsc_pkg::KIND_FIRST;
        else if (hits_d[1]) kind_d = nsc_pkg::KIND_SECOND;
        else if (hits_d[2]) kind_d = nsc_pkg::KIND_THIRD;
        else                kind_d = nsc_pkg::KIND_UNKNOWN;

        if (kind_d == nsc_pkg::KIND_UNKNOWN)   status_d = nsc_pkg::STATUS_OK;
        else if (!star_d)                      status_d = nsc_pkg::STATUS_NO_STAR;
        else if (tail_d == nsc_pkg::TAIL_BAD)  status_d = nsc_pkg::STATUS_BAD_TEXT;
        else if (ovf_d || hex_d != xor_d)      status_d = nsc_pkg::STATUS_MISMATCH;
        else                                   status_d = nsc_pkg::STATUS_OK;

        csum_d      = xor_d;
        rsum_d      = star_d ? hex_d : 8'h00;
        out_valid_d = 1'b1;

        // back to the start of a sentence
        xor_d    = '0;
        first_d  = 1'b1;
        star_d   = 1'b0;
        hex_d    = '0;
        ovf_d    = 1'b0;
        tail_d   = nsc_pkg::TAIL_DIGITS;
        recent_d = '0;
        hits_d   = '0;
        fill_d   = '0;
      end
    end
  end

  // sentence state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q       <= '0;
      first_q     <= 1'b1;
      star_q      <= 1'b0;
      hex_q       <= '0;
      ovf_q       <= 1'b0;
      tail_q      <= nsc_pkg::TAIL_DIGITS;
      recent_q    <= '0;
      hits_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      xor_q       <= xor_d;
      first_q     <= first_d;
      star_q      <= star_d;
      hex_q       <= hex_d;
      ovf_q       <= ovf_d;
      tail_q      <= tail_d;
      recent_q    <= recent_d;
      hits_q      <= hits_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (advance_s && in_eos_q) begin
      status_q <= status_d;
      kind_q   <= kind_d;
      csum_q   <= csum_d;
      rsum_q   <= rsum_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.sentence_kind = kind_q;
  assign out_o.computed_sum  = csum_q;
  assign out_o.received_sum  = rsum_q;

`ifndef SYNTH
  // state is back at sentence start after a final byte
  a_clear_after_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_s && in_eos_q |=> first_q && !star_q && hits_q == 3'd0 && fill_q == 2'd0)
    else $error("sentence state not cleared after final byte");

  // saturation pins the received value
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> hex_q == 8'hFF)
    else $error("checksum overflow without saturation");

  // tail state only moves once a star is seen
  a_tail_needs_star: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !star_q |-> hex_q == 8'h00 && tail_q == nsc_pkg::TAIL_DIGITS && !ovf_q)
    else $error("checksum tail active without star");

  // window fill saturates at two bytes
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("tag window fill out of range");

  // a finished word is never dropped by a new verdict
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q)
    else $error("pending verdict lost");
`endif

endmodule

>>> sv/nmea_sentence_checker.sv
`timescale 1ns / 1ps
// a verdict word comes from the input register through the result register
// throughput: one byte per cycle while no unread verdict word is pending
// a pending verdict word does not block the next byte unless it is still unread
// reset (rst_ni, asynchronous, active low): sentence state cleared, channels empty,
// tag registers return to GGA, RMC and ZDA

module nmea_sentence_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  nsc_in_if.sink                    in_i,
  nsc_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [nsc_pkg::AddrW-1:0] paddr,
  input  logic [nsc_pkg::DataW-1:0] pwdata,
  output logic [nsc_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  nsc_pkg::nsc_tags_t tags_s;

  // configuration registers
  nsc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tags_o  (tags_s)
  );

  // byte processing and verdict
  nsc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tags_i (tags_s),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
